// ===== hdl/pic_pkg.sv =====
package pic_pkg;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_RAISE = 2'd2,
      CMD_ACK   = 2'd3
   } cmd_type;

   // port 0 write decode
   localparam logic [7:0] ICW1_FLAG  = 8'h10;
   localparam logic [7:0] OCW3_MASK  = 8'h98;
   localparam logic [7:0] OCW3_MATCH = 8'h08;
   localparam logic [7:0] EOI_FLAG   = 8'h20;

   // initialization slots on port 1
   localparam logic [2:0] STEP_ICW1   = 3'd1;
   localparam logic [2:0] STEP_ICW2   = 3'd2;
   localparam logic [2:0] STEP_ICW3   = 3'd3;
   localparam logic [2:0] STEP_ICW4   = 3'd4;
   localparam logic [2:0] STEP_MASKED = 3'd5;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] vector;
      logic       vector_valid;
      logic       pending;
   } pic_result_type;

   // index of the lowest set bit, zero when none set
   function automatic logic [2:0] lowest_bit(input logic [7:0] v);
      logic [2:0] idx;
      idx = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== hdl/pic_core.sv =====
module pic_core
   import pic_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           exec,
   input  logic [1:0]     command,
   input  logic           port_select,
   input  logic [7:0]     write_data,
   input  logic [2:0]     irq_line,
   output pic_result_type result
);

   logic [7:0] request_ff, request_in;
   logic [7:0] service_ff, service_in;
   logic [7:0] mask_ff, mask_in;
   logic       ris_ff, ris_in;
   logic [2:0] step_ff, step_in;
   logic       single_ff, single_in;
   logic [7:0] base_ff, base_in;

   cmd_type    cmd;
   logic [7:0] live;
   logic [2:0] live_idx;
   logic [2:0] eoi_idx;
   logic [2:0] slot;

   assign cmd      = cmd_type'(command);
   assign live     = request_ff & ~mask_ff;
   assign live_idx = lowest_bit(live);
   assign eoi_idx  = lowest_bit(service_ff);

   always_comb begin
      request_in = request_ff;
      service_in = service_ff;
      mask_in    = mask_ff;
      ris_in     = ris_ff;
      step_in    = step_ff;
      single_in  = single_ff;
      base_in    = base_ff;
      slot       = step_ff;
      result     = '0;

      unique case (cmd)
         CMD_READ: begin
            if (!port_select) begin
               result.read_data = ris_ff ? service_ff : request_ff;
            end else begin
               result.read_data = mask_ff;
            end
         end
         CMD_WRITE: begin
            if (!port_select) begin
               if ((write_data & ICW1_FLAG) != 8'd0) begin
                  mask_in   = 8'd0;
                  single_in = write_data[1];
                  step_in   = STEP_ICW2;
               end else begin
                  if ((write_data & OCW3_MASK) == OCW3_MATCH && write_data[1]) begin
                     ris_in = write_data[0];
                  end
                  if ((write_data & EOI_FLAG) != 8'd0 && service_ff != 8'd0) begin
                     service_in[eoi_idx] = 1'b0;
                  end
               end
            end else begin
               // icw3 is skipped in single mode
               if (step_ff == STEP_ICW3 && single_ff) begin
                  slot = STEP_ICW4;
               end
               if (slot < STEP_MASKED) begin
                  if (slot == STEP_ICW1) begin
                     single_in = write_data[1];
                  end else if (slot == STEP_ICW2) begin
                     base_in = write_data;
                  end
                  step_in = slot + 3'd1;
               end else begin
                  mask_in = write_data;
               end
            end
         end
         CMD_RAISE: begin
            request_in[irq_line] = 1'b1;
         end
         CMD_ACK: begin
            if (live != 8'd0) begin
               request_in[live_idx] = 1'b0;
               service_in[live_idx] = 1'b1;
               result.vector        = base_ff + {5'd0, live_idx};
               result.vector_valid  = 1'b1;
            end
         end
      endcase

      result.pending = (request_in & ~mask_in) != 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         request_ff <= '0;
         service_ff <= '0;
         mask_ff    <= '0;
         ris_ff     <= 1'b0;
         step_ff    <= '0;
         single_ff  <= 1'b0;
         base_ff    <= '0;
      end else if (exec) begin
         request_ff <= request_in;
         service_ff <= service_in;
         mask_ff    <= mask_in;
         ris_ff     <= ris_in;
         step_ff    <= step_in;
         single_ff  <= single_in;
         base_ff    <= base_in;
      end
   end

   // an acknowledge that returns a vector leaves a line in service
   a_ack_service: assert property (@(posedge clock) disable iff (reset)
      exec && cmd == CMD_ACK && result.vector_valid |=> service_ff != 8'd0)
      else $error("acknowledged line not in service");

   // initialization progress never runs past the mask slot
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_MASKED)
      else $error("init step out of range");

   // an acknowledge clears the line it reports
   a_ack_clears: assert property (@(posedge clock) disable iff (reset)
      exec && cmd == CMD_ACK && result.vector_valid |=> !request_ff[$past(live_idx)])
      else $error("acknowledged request still raised");

endmodule

// ===== hdl/priority_interrupt_controller.sv =====
// eight-line priority interrupt controller in the style of the classic pic, simplified.
// each request carries one command: bus read, bus write, raise a request line or
// interrupt acknowledge; line 0 has highest priority, fixed. every request gives
// exactly one response, through the input stage and then the response register, and a
// new request is taken every cycle unless the block holds off requests, which it only
// does while a response waits under rsp_stall and the input stage is full.
// port 0 reads give the request register, or the in-service register after ocw3
// selects it; port 1 reads give the mask. write port 0 with bit 4 set to start
// initialisation, then icw2 (vector base) and icw3/icw4 on port 1 (icw3 skipped in
// single mode); later port 1 writes set the mask. pending reports any unmasked
// request left after the command.
module priority_interrupt_controller
   import pic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic       req_port_select,
   input  logic [7:0] req_write_data,
   input  logic [2:0] req_irq_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic [7:0] rsp_vector,
   output logic       rsp_vector_valid,
   output logic       rsp_pending
);

   // input stage
   logic       stage_valid_ff, stage_valid_in;
   logic [1:0] stage_command_ff;
   logic       stage_port_ff;
   logic [7:0] stage_data_ff;
   logic [2:0] stage_line_ff;

   // response register
   logic           rsp_valid_ff, rsp_valid_in;
   pic_result_type rsp_ff;
   pic_result_type result;

   logic advance;
   logic take;

   // the stage moves on when the response register is free or being emptied
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = stage_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign stage_valid_in = take || (stage_valid_ff && !advance);
   assign rsp_valid_in   = advance ? stage_valid_ff : rsp_valid_ff;

   pic_core u_core (
      .clock       (clock),
      .reset       (reset),
      .exec        (stage_valid_ff && advance),
      .command     (stage_command_ff),
      .port_select (stage_port_ff),
      .write_data  (stage_data_ff),
      .irq_line    (stage_line_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (take) begin
         stage_command_ff <= req_command;
         stage_port_ff    <= req_port_select;
         stage_data_ff    <= req_write_data;
         stage_line_ff    <= req_irq_line;
      end
      if (stage_valid_ff && advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_ff.read_data;
   assign rsp_vector       = rsp_ff.vector;
   assign rsp_vector_valid = rsp_ff.vector_valid;
   assign rsp_pending      = rsp_ff.pending;

   // requests are held off only while the input stage and the response register both hold one
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage_valid_ff && rsp_valid_ff)
      else $error("request stalled with nothing queued");

   // no vector without the valid flag
   a_vector_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_vector_valid |-> rsp_vector == 8'd0)
      else $error("vector set without vector_valid");

   // a response never carries both read data and a vector
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_data != 8'd0 |-> !rsp_vector_valid)
      else $error("read data and vector in one response");

endmodule
